FILE: rtl/icrs_pkg.sv
package icrs_pkg;

    localparam int SYMBOL_W     = 8;
    localparam int COUNT_W      = 8;
    localparam int INDEX_W      = 5;
    localparam int RESULT_LIMIT = 32;

    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    typedef struct packed {
        logic                start;
        logic [SYMBOL_W-1:0] symbol;
        logic                has_symbol;
        logic                close;
    } cnt_req_t;

    typedef struct packed {
        logic               done;
        logic               rec_valid;
        logic [COUNT_W-1:0] rec_count;
    } cnt_rsp_t;

endpackage

FILE: rtl/inversion_count_record_sort.sv
// Inversion-count record sort.
// Input channel (s_*): one transaction per byte of a string. has_symbol=0 lets a
// string close without a byte; end_of_string closes a string, end_of_set closes
// the current string and the set, and starts the sort.
// Result channel (m_*): one transaction per stored string in ascending order of
// inversion_total (ties in arrival order), at most 32 per set; last_result
// flags the final one. The set is then cleared.
// Per byte, one comparator walks the bytes already stored for the string,
// one per cycle, then stores the byte; items without a byte, or with a byte
// past MAX_LENGTH, skip the walk and are not stored. s_ready is low while a
// transaction is worked on.
// Sort: each result is found by a selection scan over the record memory with
// one key compare per cycle. While a result waits on m_ready the block holds it
// and takes no input. Reset (aresetn low, synchronous) empties the current
// string and the set.
module inversion_count_record_sort
    import icrs_pkg::*;
#(
    parameter int MAX_LENGTH  = 19,
    parameter int MAX_STRINGS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SYMBOL_W-1:0] s_symbol,
    input  logic                s_has_symbol,
    input  logic                s_end_of_string,
    input  logic                s_end_of_set,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [INDEX_W-1:0]  m_string_index,
    output logic [COUNT_W-1:0]  m_inversion_total,
    output logic                m_last_result
);

    typedef enum logic [1:0] {T_IDLE, T_COUNT, T_SORT} state_t;

    state_t   state_reg, state_next;
    logic     eoset_reg, eoset_next;
    cnt_req_t req;
    cnt_rsp_t rsp;
    logic     sort_start;
    logic     sort_busy;

    assign s_ready        = (state_reg == T_IDLE);
    assign req.start      = s_valid && s_ready;
    assign req.symbol     = s_symbol;
    assign req.has_symbol = s_has_symbol;
    assign req.close      = s_end_of_string || s_end_of_set;
    assign sort_start     = (state_reg == T_COUNT) && rsp.done && eoset_reg;

    always_comb begin
        state_next = state_reg;
        eoset_next = eoset_reg;
        unique case (state_reg)
            T_IDLE: begin
                if (req.start) begin
                    eoset_next = s_end_of_set;
                    state_next = T_COUNT;
                end
            end
            T_COUNT: begin
                if (rsp.done) begin
                    state_next = eoset_reg ? T_SORT : T_IDLE;
                end
            end
            T_SORT: begin
                if (!sort_busy) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            eoset_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            eoset_reg <= eoset_next;
        end
    end

    icrs_counter #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_counter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    icrs_sorter #(
        .MAX_STRINGS (MAX_STRINGS)
    ) u_sorter (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .rec               (rsp),
        .sort_start        (sort_start),
        .busy              (sort_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_string_index    (m_string_index),
        .m_inversion_total (m_inversion_total),
        .m_last_result     (m_last_result)
    );

endmodule

FILE: rtl/icrs_counter.sv
module icrs_counter
    import icrs_pkg::*;
#(
    parameter int MAX_LENGTH = 19
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cnt_req_t req,
    output cnt_rsp_t rsp
);

    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam int IW = $clog2(MAX_LENGTH);

    typedef enum logic [1:0] {C_IDLE, C_SCAN, C_FIN} state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       ptr_reg, ptr_next;
    logic [COUNT_W-1:0]  run_reg, run_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [SYMBOL_W-1:0] rd_data_reg;
    logic [SYMBOL_W-1:0] sym_reg, sym_next;
    logic                close_reg, close_next;

    logic [SYMBOL_W-1:0] mem [MAX_LENGTH];

    logic rd_en;
    logic wr_en;

    assign rd_en = (state_reg == C_SCAN) && (ptr_reg < len_reg);
    assign wr_en = (state_reg == C_SCAN) && !rd_en && !rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[ptr_reg[IW-1:0]];
        end
        if (wr_en) begin
            mem[len_reg[IW-1:0]] <= sym_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        ptr_next    = ptr_reg;
        run_next    = run_reg;
        rd_vld_next = 1'b0;
        sym_next    = sym_reg;
        close_next  = close_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (req.start) begin
                    sym_next   = req.symbol;
                    close_next = req.close;
                    ptr_next   = '0;
                    if (req.has_symbol && (len_reg < LW'(MAX_LENGTH))) begin
                        state_next = C_SCAN;
                    end else begin
                        state_next = C_FIN;
                    end
                end
            end
            C_SCAN: begin
                if (rd_en) begin
                    ptr_next    = ptr_reg + LW'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg && (rd_data_reg > sym_reg) && (run_reg != COUNT_SAT)) begin
                    run_next = run_reg + COUNT_W'(1);
                end
                if (wr_en) begin
                    len_next   = len_reg + LW'(1);
                    state_next = C_FIN;
                end
            end
            C_FIN: begin
                if (close_reg) begin
                    len_next = '0;
                    run_next = '0;
                end
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= C_IDLE;
            len_reg    <= '0;
            run_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            run_reg    <= run_next;
            rd_vld_reg <= rd_vld_next;
        end
        ptr_reg   <= ptr_next;
        sym_reg   <= sym_next;
        close_reg <= close_next;
    end

    assign rsp.done      = (state_reg == C_FIN);
    assign rsp.rec_valid = (state_reg == C_FIN) && close_reg;
    assign rsp.rec_count = run_reg;

endmodule

FILE: rtl/icrs_sorter.sv
module icrs_sorter
    import icrs_pkg::*;
#(
    parameter int MAX_STRINGS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cnt_rsp_t           rec,
    input  logic               sort_start,
    output logic               busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_string_index,
    output logic [COUNT_W-1:0] m_inversion_total,
    output logic               m_last_result
);

    localparam int NW        = $clog2(MAX_STRINGS + 1);
    localparam int SW        = $clog2(MAX_STRINGS);
    localparam int OUT_LIMIT = (MAX_STRINGS < RESULT_LIMIT) ? MAX_STRINGS : RESULT_LIMIT;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

    state_t             state_reg, state_next;
    logic [NW-1:0]      loaded_reg, loaded_next;
    logic [NW-1:0]      ptr_reg, ptr_next;
    logic [NW-1:0]      out_cnt_reg, out_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [SW-1:0]      rd_addr_reg, rd_addr_next;
    logic [COUNT_W-1:0] rd_data_reg;
    logic [COUNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic [SW-1:0]      best_idx_reg, best_idx_next;
    logic               found_reg, found_next;
    logic [COUNT_W-1:0] prev_cnt_reg, prev_cnt_next;
    logic [SW-1:0]      prev_idx_reg, prev_idx_next;

    logic [COUNT_W-1:0] mem [MAX_STRINGS];

    logic          rd_en;
    logic          wr_en;
    logic          above_prev;
    logic          below_best;
    logic [NW-1:0] n_total;
    logic          last;

    assign rd_en = (state_reg == S_SCAN) && (ptr_reg < loaded_reg);
    assign wr_en = rec.rec_valid && (loaded_reg < NW'(MAX_STRINGS));

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[ptr_reg[SW-1:0]];
        end
        if (wr_en) begin
            mem[loaded_reg[SW-1:0]] <= rec.rec_count;
        end
    end

    // stable order: ties resolved by arrival position
    assign above_prev = (out_cnt_reg == '0) ||
                        ({rd_data_reg, rd_addr_reg} > {prev_cnt_reg, prev_idx_reg});
    assign below_best = !found_reg ||
                        ({rd_data_reg, rd_addr_reg} < {best_cnt_reg, best_idx_reg});
    assign n_total    = (loaded_reg > NW'(OUT_LIMIT)) ? NW'(OUT_LIMIT) : loaded_reg;
    assign last       = ((out_cnt_reg + NW'(1)) == n_total);

    always_comb begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        ptr_next      = ptr_reg;
        out_cnt_next  = out_cnt_reg;
        rd_vld_next   = 1'b0;
        rd_addr_next  = rd_addr_reg;
        best_cnt_next = best_cnt_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        prev_cnt_next = prev_cnt_reg;
        prev_idx_next = prev_idx_reg;
        if (wr_en) begin
            loaded_next = loaded_reg + NW'(1);
        end
        unique case (state_reg)
            S_IDLE: begin
                if (sort_start) begin
                    state_next   = S_SCAN;
                    ptr_next     = '0;
                    out_cnt_next = '0;
                    found_next   = 1'b0;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    rd_addr_next = ptr_reg[SW-1:0];
                    ptr_next     = ptr_reg + NW'(1);
                    rd_vld_next  = 1'b1;
                end
                if (rd_vld_reg && above_prev && below_best) begin
                    best_cnt_next = rd_data_reg;
                    best_idx_next = rd_addr_reg;
                    found_next    = 1'b1;
                end
                if (!rd_en && !rd_vld_reg) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    prev_cnt_next = best_cnt_reg;
                    prev_idx_next = best_idx_reg;
                    out_cnt_next  = out_cnt_reg + NW'(1);
                    found_next    = 1'b0;
                    ptr_next      = '0;
                    if (last) begin
                        loaded_next = '0;
                        state_next  = S_IDLE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            loaded_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            rd_vld_reg <= rd_vld_next;
        end
        ptr_reg      <= ptr_next;
        out_cnt_reg  <= out_cnt_next;
        rd_addr_reg  <= rd_addr_next;
        best_cnt_reg <= best_cnt_next;
        best_idx_reg <= best_idx_next;
        found_reg    <= found_next;
        prev_cnt_reg <= prev_cnt_next;
        prev_idx_reg <= prev_idx_next;
    end

    assign busy              = (state_reg != S_IDLE);
    assign m_valid           = (state_reg == S_OUT);
    assign m_string_index    = INDEX_W'(best_idx_reg);
    assign m_inversion_total = best_cnt_reg;
    assign m_last_result     = last;

endmodule
